// ===== rtl/dmls_pkg.sv =====
// Shared types and constants for the door motor limit sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dmls_pkg;

	localparam int DUTY_BITS = 8;
	localparam int TIMER_BITS = 16;
	localparam int UNBLOCK_TRIES = 2;
	localparam int TIMEOUT_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int IN_TDATA_BITS = 8;
	localparam int OUT_TDATA_BITS = 40;

	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_OPEN_FRONT = 3'd1;
	localparam logic [2:0] MODE_CLOSE_FRONT = 3'd2;
	localparam logic [2:0] MODE_OPEN_REAR = 3'd3;
	localparam logic [2:0] MODE_CLOSE_REAR = 3'd4;
	localparam logic [2:0] MODE_HOME = 3'd5;

	localparam logic [1:0] OUTCOME_NONE = 2'd0;
	localparam logic [1:0] OUTCOME_OK = 2'd1;
	localparam logic [1:0] OUTCOME_FAIL = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRONT_DUTY = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REAR_DUTY = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_TIMEOUT = 2'd2;

	localparam logic [DUTY_BITS-1:0] DUTY_RESET = 8'd255;
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd5000;

	typedef struct packed {
		logic       rear_closed_limit;
		logic       rear_open_limit;
		logic       front_closed_limit;
		logic       front_open_limit;
		logic [2:0] mode;
	} item_t;

	typedef struct packed {
		logic                 rear_is_open;
		logic                 front_is_open;
		logic [1:0]           outcome;
		logic                 busy_res;
		logic [DUTY_BITS-1:0] rear_close_drive;
		logic [DUTY_BITS-1:0] rear_open_drive;
		logic [DUTY_BITS-1:0] front_close_drive;
		logic [DUTY_BITS-1:0] front_open_drive;
	} result_t;

	typedef struct packed {
		logic                      valid;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/door_motor_limit_sequencer_top.sv =====
// Door motor limit sequencer, top level.
// Channels: s_axis carries one millisecond tick item per transfer (command and
// the four limit switches); m_axis returns exactly one result item per tick
// item (four channel duties, busy, outcome, confirmed door positions).
// The cfg channel writes front duty (index 0), rear duty (index 1) and the
// per-phase timeout in ticks (index 2); it is always ready and should only be
// used while no move is in progress. Other indexes are ignored.
// Flow: an accepted tick item waits in the input register, and the combinational
// update loads its result into the result register. Throughput: one item per
// cycle while the receiver keeps m_axis_tready high, set by the combinational
// update between the two registers.
// Reset: arst_n clears the motion state and positions (both doors closed),
// restores duties to 255 and the timeout to 5000, and empties both registers.
// Stall: while m_axis_tready is low the result holds; a tick item is still taken
// into the input register while it is empty, after which s_axis_tready drops.
// Depends on dmls_pkg, dmls_in_reg, dmls_core and dmls_out_reg.
`default_nettype none

module door_motor_limit_sequencer_top #(
	parameter int TIMER_BITS = dmls_pkg::TIMER_BITS,
	parameter int UNBLOCK_TRIES = dmls_pkg::UNBLOCK_TRIES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// mode[2:0], front_open_limit[3], front_closed_limit[4], rear_open_limit[5],
	// rear_closed_limit[6], zero[7]
	input  wire logic [dmls_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// front_open_drive[7:0], front_close_drive[15:8], rear_open_drive[23:16],
	// rear_close_drive[31:24], busy_res[32], outcome[34:33], front_is_open[35],
	// rear_is_open[36], zero[39:37]
	output logic [dmls_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dmls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [dmls_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	dmls_pkg::item_t   item, item_s1;
	dmls_pkg::result_t res, res_q;
	dmls_pkg::cfg_wr_t cfg;
	logic              valid_s1, advance, fire, load;

	assign item = s_axis_tdata[$bits(dmls_pkg::item_t)-1:0];
	assign s_axis_tready = !valid_s1 || advance;
	assign load = s_axis_tvalid && s_axis_tready;
	assign fire = valid_s1 && advance;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	dmls_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.item     (item),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dmls_core #(
		.TIMER_BITS    (TIMER_BITS),
		.UNBLOCK_TRIES (UNBLOCK_TRIES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.item_s1 (item_s1),
		.res     (res)
	);

	dmls_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.res         (res),
		.out_ready   (m_axis_tready),
		.out_valid_q (m_axis_tvalid),
		.res_q       (res_q),
		.advance     (advance)
	);

	assign m_axis_tdata = {
		(dmls_pkg::OUT_TDATA_BITS - $bits(dmls_pkg::result_t))'(0), res_q
	};

endmodule

`default_nettype wire

// ===== rtl/dmls_in_reg.sv =====
// Input register stage: holds one accepted tick item for the sequencer core.
// Depends on dmls_pkg for the item type.
`default_nettype none

module dmls_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire dmls_pkg::item_t item,
	input  wire logic            fire,
	output logic                 valid_s1,
	output dmls_pkg::item_t      item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmls_core.sv =====
// Sequencer core: configuration registers, motion state and the per-tick update.
// Depends on dmls_pkg for item, result and configuration types.
`default_nettype none

module dmls_core #(
	parameter int TIMER_BITS = dmls_pkg::TIMER_BITS,
	parameter int UNBLOCK_TRIES = dmls_pkg::UNBLOCK_TRIES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dmls_pkg::cfg_wr_t cfg,
	input  wire logic              fire,
	input  wire dmls_pkg::item_t   item_s1,
	output dmls_pkg::result_t      res
);

	localparam int RETRY_BITS = $clog2(UNBLOCK_TRIES + 1);
	localparam int CMP_BITS = (TIMER_BITS > dmls_pkg::TIMEOUT_BITS) ?
		TIMER_BITS : dmls_pkg::TIMEOUT_BITS;

	typedef enum logic [1:0] {PH_IDLE, PH_DRIVE, PH_BACK, PH_FWD} phase_t;

	logic [dmls_pkg::DUTY_BITS-1:0]    front_duty_q, rear_duty_q;
	logic [dmls_pkg::TIMEOUT_BITS-1:0] move_timeout_q;

	phase_t                phase_q, phase_d;
	logic                  motor_q, motor_d;
	logic                  target_q, target_d;
	logic                  homing_q, homing_d;
	logic [RETRY_BITS-1:0] retry_q, retry_d;
	logic [RETRY_BITS:0]   retry_inc;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic                  front_open_q, front_open_d;
	logic                  rear_open_q, rear_open_d;
	logic [1:0]            outcome_d;
	logic                  target_sw, opposite_sw, timed_out, open_ch;
	logic [dmls_pkg::DUTY_BITS-1:0] duty;
	logic [2:0]            mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_duty_q   <= dmls_pkg::DUTY_RESET;
			rear_duty_q    <= dmls_pkg::DUTY_RESET;
			move_timeout_q <= dmls_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dmls_pkg::CFG_FRONT_DUTY:   front_duty_q <= cfg.data[dmls_pkg::DUTY_BITS-1:0];
				dmls_pkg::CFG_REAR_DUTY:    rear_duty_q <= cfg.data[dmls_pkg::DUTY_BITS-1:0];
				dmls_pkg::CFG_MOVE_TIMEOUT: move_timeout_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode = item_s1.mode;
		phase_d = phase_q;
		motor_d = motor_q;
		target_d = target_q;
		homing_d = homing_q;
		retry_d = retry_q;
		timer_d = timer_q;
		front_open_d = front_open_q;
		rear_open_d = rear_open_q;
		outcome_d = dmls_pkg::OUTCOME_NONE;
		retry_inc = '0;

		// a command is only taken when nothing is moving
		if (phase_q == PH_IDLE && mode >= dmls_pkg::MODE_OPEN_FRONT &&
				mode <= dmls_pkg::MODE_HOME) begin
			motor_d = (mode == dmls_pkg::MODE_OPEN_REAR) || (mode == dmls_pkg::MODE_CLOSE_REAR);
			target_d = (mode == dmls_pkg::MODE_OPEN_FRONT) || (mode == dmls_pkg::MODE_OPEN_REAR);
			homing_d = (mode == dmls_pkg::MODE_HOME);
			retry_d = '0;
			timer_d = '0;
			phase_d = PH_DRIVE;
		end

		if (!motor_d) begin
			target_sw = target_d ? item_s1.front_open_limit : item_s1.front_closed_limit;
			opposite_sw = target_d ? item_s1.front_closed_limit : item_s1.front_open_limit;
		end else begin
			target_sw = target_d ? item_s1.rear_open_limit : item_s1.rear_closed_limit;
			opposite_sw = target_d ? item_s1.rear_closed_limit : item_s1.rear_open_limit;
		end
		timed_out = (CMP_BITS'(timer_d) >= CMP_BITS'(move_timeout_q)) || (&timer_d);

		if (phase_d != PH_IDLE) begin
			if (phase_d == PH_DRIVE || phase_d == PH_FWD) begin
				if (target_sw) begin
					retry_d = '0;
					if (!motor_d) begin
						front_open_d = target_d;
					end else begin
						rear_open_d = target_d;
					end
					// home goes on to the rear door after the front one closes
					if (homing_d && !motor_d) begin
						homing_d = 1'b0;
						motor_d = 1'b1;
						target_d = 1'b0;
						phase_d = PH_DRIVE;
						timer_d = '0;
					end else begin
						phase_d = PH_IDLE;
						homing_d = 1'b0;
						outcome_d = dmls_pkg::OUTCOME_OK;
					end
				end else if (timed_out) begin
					if (phase_d == PH_DRIVE) begin
						retry_d = '0;
						phase_d = PH_BACK;
						timer_d = '0;
					end else begin
						retry_inc = {1'b0, retry_d} + 1'b1;
						if (retry_inc >= (RETRY_BITS + 1)'(UNBLOCK_TRIES)) begin
							phase_d = PH_IDLE;
							homing_d = 1'b0;
							retry_d = '0;
							outcome_d = dmls_pkg::OUTCOME_FAIL;
						end else begin
							retry_d = retry_inc[RETRY_BITS-1:0];
							phase_d = PH_BACK;
							timer_d = '0;
						end
					end
				end else begin
					timer_d = timer_d + 1'b1;
				end
			end else begin
				if (opposite_sw) begin
					phase_d = PH_FWD;
					timer_d = '0;
				end else if (timed_out) begin
					retry_inc = {1'b0, retry_d} + 1'b1;
					if (retry_inc >= (RETRY_BITS + 1)'(UNBLOCK_TRIES)) begin
						phase_d = PH_IDLE;
						homing_d = 1'b0;
						retry_d = '0;
						outcome_d = dmls_pkg::OUTCOME_FAIL;
					end else begin
						retry_d = retry_inc[RETRY_BITS-1:0];
						phase_d = PH_BACK;
						timer_d = '0;
					end
				end else begin
					timer_d = timer_d + 1'b1;
				end
			end
		end

		open_ch = (phase_d == PH_BACK) ? !target_d : target_d;
		duty = motor_d ? rear_duty_q : front_duty_q;
		res = '0;
		if (phase_d != PH_IDLE) begin
			res.front_open_drive = (!motor_d && open_ch) ? duty : '0;
			res.front_close_drive = (!motor_d && !open_ch) ? duty : '0;
			res.rear_open_drive = (motor_d && open_ch) ? duty : '0;
			res.rear_close_drive = (motor_d && !open_ch) ? duty : '0;
		end
		res.busy_res = (phase_d != PH_IDLE);
		res.outcome = outcome_d;
		res.front_is_open = front_open_d;
		res.rear_is_open = rear_open_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			motor_q <= 1'b0;
			target_q <= 1'b0;
			homing_q <= 1'b0;
			retry_q <= '0;
			timer_q <= '0;
			front_open_q <= 1'b0;
			rear_open_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			motor_q <= motor_d;
			target_q <= target_d;
			homing_q <= homing_d;
			retry_q <= retry_d;
			timer_q <= timer_d;
			front_open_q <= front_open_d;
			rear_open_q <= rear_open_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmls_out_reg.sv =====
// Result register: holds one result item until the receiver takes it.
// Depends on dmls_pkg for the result type.
`default_nettype none

module dmls_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire dmls_pkg::result_t res,
	input  wire logic              out_ready,
	output logic                   out_valid_q,
	output dmls_pkg::result_t      res_q,
	output logic                   advance
);

	// the core may run when the slot is free or is being emptied this cycle
	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmls_checker.sv =====
// Port-level checker for the door motor limit sequencer, bound to the top level.
// Depends on dmls_pkg for widths and outcome codes.
`default_nettype none

module dmls_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                m_axis_tvalid,
	input wire logic                                m_axis_tready,
	input wire logic [dmls_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

	logic [1:0] outcome;
	logic       busy;
	logic [3:0] ch_on;

	assign outcome = m_axis_tdata[34:33];
	assign busy = m_axis_tdata[32];
	assign ch_on = {|m_axis_tdata[31:24], |m_axis_tdata[23:16],
		|m_axis_tdata[15:8], |m_axis_tdata[7:0]};

	// a stalled result item stays offered and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// a finished sequence leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (outcome != dmls_pkg::OUTCOME_NONE) |-> !busy)
		else $error("outcome reported while still busy");

	// nothing is driven when idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !busy |-> (ch_on == 4'b0000))
		else $error("motor channel driven while idle");

	// only one channel of one motor at a time
	a_one_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $countones(ch_on) <= 1)
		else $error("more than one motor channel driven");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (outcome == dmls_pkg::OUTCOME_NONE) ||
			(outcome == dmls_pkg::OUTCOME_OK) || (outcome == dmls_pkg::OUTCOME_FAIL))
		else $error("undefined outcome code");

endmodule

bind door_motor_limit_sequencer_top dmls_checker u_dmls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/door_motor_limit_sequencer_top_tb.sv =====
// Testbench for door_motor_limit_sequencer_top: drives tick items on the stream input,
// predicts every result item in a local model of the sequencer and checks them in order.
// Depends on dmls_pkg and the top level of the block.
`timescale 1ns / 100ps

module door_motor_limit_sequencer_top_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PIPE_LATENCY = 2;
	localparam int STALL_LEN = 120;
	localparam int RANDOM_ITEMS = 530;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam logic [dmls_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
	localparam logic [dmls_pkg::TIMER_BITS-1:0] TICK_MAX = '1;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_DRIVE, SEQ_BACK, SEQ_FWD} seq_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [dmls_pkg::IN_TDATA_BITS-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [dmls_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dmls_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [dmls_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	// local copy of the sequencer state and its registers
	seq_phase_t seq_ph = SEQ_IDLE;
	logic rear_sel = 1'b0;
	logic want_open = 1'b0;
	logic home_next = 1'b0;
	logic [1:0] tries = '0;
	logic [dmls_pkg::TIMER_BITS-1:0] ticks = '0;
	logic front_open_pos = 1'b0;
	logic rear_open_pos = 1'b0;
	logic [dmls_pkg::DUTY_BITS-1:0] front_duty_cfg = dmls_pkg::DUTY_RESET;
	logic [dmls_pkg::DUTY_BITS-1:0] rear_duty_cfg = dmls_pkg::DUTY_RESET;
	logic [dmls_pkg::TIMEOUT_BITS-1:0] timeout_cfg = dmls_pkg::TIMEOUT_RESET;

	dmls_pkg::result_t expected_results[$];
	int mismatches = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int cycles = 0;

	door_motor_limit_sequencer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			stall_left <= STALL_LEN;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		dmls_pkg::result_t want;
		dmls_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = dmls_pkg::result_t'(m_axis_tdata[$bits(dmls_pkg::result_t)-1:0]);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("front_open_drive", want.front_open_drive, got.front_open_drive);
				check_field("front_close_drive", want.front_close_drive, got.front_close_drive);
				check_field("rear_open_drive", want.rear_open_drive, got.rear_open_drive);
				check_field("rear_close_drive", want.rear_close_drive, got.rear_close_drive);
				check_field("busy_res", want.busy_res, got.busy_res);
				check_field("outcome", want.outcome, got.outcome);
				check_field("front_is_open", want.front_is_open, got.front_is_open);
				check_field("rear_is_open", want.rear_is_open, got.rear_is_open);
			end
		end
	end

	function automatic logic [1:0] retry_unblock();
		tries++;
		if (tries >= dmls_pkg::UNBLOCK_TRIES) begin
			seq_ph = SEQ_IDLE;
			home_next = 1'b0;
			tries = '0;
			return dmls_pkg::OUTCOME_FAIL;
		end
		seq_ph = SEQ_BACK;
		ticks = '0;
		return dmls_pkg::OUTCOME_NONE;
	endfunction

	// one tick of the sequencer: updates the local state, returns the result item
	function automatic dmls_pkg::result_t next_door_outputs(input dmls_pkg::item_t it);
		dmls_pkg::result_t r;
		logic target_hit;
		logic opposite_hit;
		logic expired;
		logic open_ch;
		logic [dmls_pkg::DUTY_BITS-1:0] duty;
		r = '0;
		r.outcome = dmls_pkg::OUTCOME_NONE;
		if (seq_ph == SEQ_IDLE && it.mode >= dmls_pkg::MODE_OPEN_FRONT &&
				it.mode <= dmls_pkg::MODE_HOME) begin
			rear_sel = (it.mode == dmls_pkg::MODE_OPEN_REAR ||
				it.mode == dmls_pkg::MODE_CLOSE_REAR);
			want_open = (it.mode == dmls_pkg::MODE_OPEN_FRONT ||
				it.mode == dmls_pkg::MODE_OPEN_REAR);
			home_next = (it.mode == dmls_pkg::MODE_HOME);
			tries = '0;
			ticks = '0;
			seq_ph = SEQ_DRIVE;
		end
		if (seq_ph != SEQ_IDLE) begin
			if (rear_sel) begin
				target_hit = want_open ? it.rear_open_limit : it.rear_closed_limit;
				opposite_hit = want_open ? it.rear_closed_limit : it.rear_open_limit;
			end else begin
				target_hit = want_open ? it.front_open_limit : it.front_closed_limit;
				opposite_hit = want_open ? it.front_closed_limit : it.front_open_limit;
			end
			// a saturated timer blocks whatever the timeout
			expired = (ticks >= timeout_cfg) || (ticks == TICK_MAX);
			if (seq_ph == SEQ_DRIVE || seq_ph == SEQ_FWD) begin
				if (target_hit) begin
					tries = '0;
					if (rear_sel)
						rear_open_pos = want_open;
					else
						front_open_pos = want_open;
					if (home_next && !rear_sel) begin
						home_next = 1'b0;
						rear_sel = 1'b1;
						want_open = 1'b0;
						seq_ph = SEQ_DRIVE;
						ticks = '0;
					end else begin
						seq_ph = SEQ_IDLE;
						home_next = 1'b0;
						r.outcome = dmls_pkg::OUTCOME_OK;
					end
				end else if (expired) begin
					if (seq_ph == SEQ_DRIVE) begin
						tries = '0;
						seq_ph = SEQ_BACK;
						ticks = '0;
					end else begin
						r.outcome = retry_unblock();
					end
				end else if (ticks != TICK_MAX) begin
					ticks++;
				end
			end else begin
				if (opposite_hit) begin
					seq_ph = SEQ_FWD;
					ticks = '0;
				end else if (expired) begin
					r.outcome = retry_unblock();
				end else if (ticks != TICK_MAX) begin
					ticks++;
				end
			end
		end
		if (seq_ph != SEQ_IDLE) begin
			open_ch = (seq_ph == SEQ_BACK) ? !want_open : want_open;
			duty = rear_sel ? rear_duty_cfg : front_duty_cfg;
			case ({rear_sel, open_ch})
				2'b01: r.front_open_drive = duty;
				2'b00: r.front_close_drive = duty;
				2'b11: r.rear_open_drive = duty;
				default: r.rear_close_drive = duty;
			endcase
		end
		r.busy_res = (seq_ph != SEQ_IDLE);
		r.front_is_open = front_open_pos;
		r.rear_is_open = rear_open_pos;
		return r;
	endfunction

	function automatic dmls_pkg::item_t tick_item(input logic [2:0] mode, input logic fo,
			input logic fc, input logic ro, input logic rc);
		dmls_pkg::item_t it;
		it.mode = mode;
		it.front_open_limit = fo;
		it.front_closed_limit = fc;
		it.rear_open_limit = ro;
		it.rear_closed_limit = rc;
		return it;
	endfunction

	task automatic send_tick(input dmls_pkg::item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, it};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_results.push_back(next_door_outputs(it));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// every switch high ends any phase within a few ticks
	task automatic settle_sequencer();
		while (seq_ph != SEQ_IDLE)
			send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b1, 1'b1, 1'b1, 1'b1));
		drain_results();
	endtask

	task automatic write_regs(input logic [dmls_pkg::DUTY_BITS-1:0] fd,
			input logic [dmls_pkg::DUTY_BITS-1:0] rd,
			input logic [dmls_pkg::TIMEOUT_BITS-1:0] to);
		logic [dmls_pkg::CFG_INDEX_BITS-1:0] idx;
		logic [dmls_pkg::CFG_DATA_BITS-1:0] val;
		settle_sequencer();
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: begin
					idx = dmls_pkg::CFG_FRONT_DUTY;
					val = {8'($urandom_range(255)), fd};
				end
				1: begin
					idx = dmls_pkg::CFG_REAR_DUTY;
					val = {8'($urandom_range(255)), rd};
				end
				2: begin
					idx = dmls_pkg::CFG_MOVE_TIMEOUT;
					val = to;
				end
				default: begin
					idx = CFG_UNUSED;
					val = 16'($urandom_range(65535));
				end
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx)
				dmls_pkg::CFG_FRONT_DUTY: front_duty_cfg = val[dmls_pkg::DUTY_BITS-1:0];
				dmls_pkg::CFG_REAR_DUTY: rear_duty_cfg = val[dmls_pkg::DUTY_BITS-1:0];
				dmls_pkg::CFG_MOVE_TIMEOUT: timeout_cfg = val[dmls_pkg::TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// state after reset, and one move at the reset duty
	task automatic test_reset_state();
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_CLOSE_FRONT, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b1, 1'b0, 1'b0));
		drain_results();
	endtask

	task automatic test_commands();
		write_regs(8'hA5, 8'h5A, 16'd4);
		send_tick(tick_item(dmls_pkg::MODE_OPEN_FRONT, 1'b0, 1'b0, 1'b0, 1'b0));
		// commands while busy are ignored, spare modes act as plain ticks
		send_tick(tick_item(dmls_pkg::MODE_CLOSE_REAR, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(MODE_SPARE_6, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(MODE_SPARE_7, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_CLOSE_FRONT, 1'b0, 1'b1, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_OPEN_REAR, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_CLOSE_REAR, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
		// home: front already closed, so the rear door starts closing on the same tick
		send_tick(tick_item(dmls_pkg::MODE_HOME, 1'b0, 1'b1, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
		drain_results();
	endtask

	task automatic test_unblock();
		write_regs(8'h33, 8'hCC, 16'd2);
		send_tick(tick_item(dmls_pkg::MODE_OPEN_REAR, 1'b0, 1'b0, 1'b0, 1'b0));
		while (seq_ph == SEQ_DRIVE)
			send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1, 1'b0));
		// home blocked on the front door fails after both tries, rear never moves
		send_tick(tick_item(dmls_pkg::MODE_HOME, 1'b0, 1'b0, 1'b0, 1'b0));
		while (seq_ph != SEQ_IDLE)
			send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		drain_results();
	endtask

	task automatic test_zero_timeout();
		write_regs(8'h01, 8'h80, 16'd0);
		send_tick(tick_item(dmls_pkg::MODE_CLOSE_FRONT, 1'b0, 1'b1, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_OPEN_FRONT, 1'b0, 1'b0, 1'b0, 1'b0));
		while (seq_ph != SEQ_IDLE)
			send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		drain_results();
	endtask

	task automatic test_duty_extremes();
		write_regs(8'h00, 8'hFF, 16'd3);
		send_tick(tick_item(dmls_pkg::MODE_OPEN_FRONT, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_OPEN_REAR, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1, 1'b0));
		write_regs(8'hFF, 8'h00, 16'd3);
		send_tick(tick_item(dmls_pkg::MODE_HOME, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b1, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
		drain_results();
	endtask

	// receiver holds off while items keep coming, so the input side must stall
	task automatic test_backpressure();
		int saved_pct;
		saved_pct = src_idle_pct;
		src_idle_pct = 0;
		write_regs(8'h7E, 8'hE7, 16'd50);
		stall_req++;
		send_tick(tick_item(dmls_pkg::MODE_OPEN_FRONT, 1'b0, 1'b0, 1'b0, 1'b0));
		for (int i = 0; i < 40; i++)
			send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
		drain_results();
		src_idle_pct = saved_pct;
	endtask

	// largest timeout: a long move that reaches its switch well before it could block
	task automatic test_long_timeout();
		write_regs(8'h3C, 8'hC3, 16'hFFFF);
		send_tick(tick_item(dmls_pkg::MODE_OPEN_FRONT, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (300) send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(tick_item(dmls_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
		drain_results();
	endtask

	// mostly real moves with random switch noise; the awaited switch rises now and then
	task automatic test_random_sequences(input int n_items);
		dmls_pkg::item_t it;
		logic aim_open;
		for (int i = 0; i < n_items; i++) begin
			if (i % 120 == 0) begin
				case ($urandom_range(5))
					0: write_regs(8'h00, 8'hFF, 16'd1);
					1: write_regs(8'hFF, 8'h00, 16'd0);
					default: write_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
						16'($urandom_range(1, 12)));
				endcase
			end
			if (seq_ph == SEQ_IDLE) begin
				if ($urandom_range(99) < 85) begin
					it.mode = 3'($urandom_range(dmls_pkg::MODE_OPEN_FRONT, dmls_pkg::MODE_HOME));
				end else begin
					case ($urandom_range(2))
						0: it.mode = dmls_pkg::MODE_TICK;
						1: it.mode = MODE_SPARE_6;
						default: it.mode = MODE_SPARE_7;
					endcase
				end
			end else begin
				it.mode = ($urandom_range(99) < 80) ? dmls_pkg::MODE_TICK :
					3'($urandom_range(7));
			end
			it.front_open_limit = ($urandom_range(99) < 15);
			it.front_closed_limit = ($urandom_range(99) < 15);
			it.rear_open_limit = ($urandom_range(99) < 15);
			it.rear_closed_limit = ($urandom_range(99) < 15);
			if (seq_ph != SEQ_IDLE && $urandom_range(99) < 20) begin
				aim_open = (seq_ph == SEQ_BACK) ? !want_open : want_open;
				case ({rear_sel, aim_open})
					2'b00: it.front_closed_limit = 1'b1;
					2'b01: it.front_open_limit = 1'b1;
					2'b10: it.rear_closed_limit = 1'b1;
					default: it.rear_open_limit = 1'b1;
				endcase
			end
			send_tick(it);
		end
		drain_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 36;
		sink_idle_pct = 86;
		test_reset_state();
		test_commands();
		test_unblock();
		test_zero_timeout();
		test_duty_extremes();
		test_random_sequences(RANDOM_ITEMS);

		src_idle_pct = 86;
		sink_idle_pct = 36;
		test_backpressure();
		test_random_sequences(RANDOM_ITEMS);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_long_timeout();
		test_random_sequences(RANDOM_ITEMS);

		drain_results();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== door_motor_limit_sequencer_top.f =====
rtl/dmls_pkg.sv
rtl/dmls_in_reg.sv
rtl/dmls_core.sv
rtl/dmls_out_reg.sv
rtl/door_motor_limit_sequencer_top.sv
rtl/dmls_checker.sv
sim/door_motor_limit_sequencer_top_tb.sv
